### rtl/smam_pkg.sv
package smam_pkg;

  localparam int SOURCES_DEF  = 8;
  localparam int CHANNELS_DEF = 2;

  localparam int ACC_W = 35;

  localparam logic [15:0] CENTRE_LEVEL = 16'd23170;
  localparam logic [15:0] UNITY_Q15    = 16'd32768;

  localparam logic CMD_WRITE  = 1'b0;
  localparam logic CMD_SAMPLE = 1'b1;

endpackage

### rtl/send_matrix_audio_mixer.sv
// Send-matrix mixer: a write request (in_command = write) stores a Q1.15 send level for one
// source and channel. A sample request adds sample * level into each channel accumulator;
// one 19x17 multiplier is shared by everything, so each channel passes through a table
// read, a multiply and an accumulate state. A request marked last_source then scales every
// accumulator by the master volume in two partial products plus one sum per channel, and
// emits one result per channel in channel order through an output register. in_stall is
// high for the whole of that work, which waits while the output side stalls.
module send_matrix_audio_mixer #(
  parameter int SOURCES  = smam_pkg::SOURCES_DEF,
  parameter int CHANNELS = smam_pkg::CHANNELS_DEF
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               cfg_wr_en,
  input  logic        [15:0] cfg_wr_data,
  input  logic               in_valid,
  output logic               in_stall,
  input  logic               in_command,
  input  logic         [2:0] in_source_index,
  input  logic         [2:0] in_channel_index,
  input  logic        [15:0] in_level,
  input  logic signed [15:0] in_sample,
  input  logic               in_last_source,
  output logic               out_valid,
  input  logic               out_stall,
  output logic signed [15:0] out_sample,
  output logic         [2:0] out_channel,
  output logic               out_last_channel,
  output logic               out_clipped
);

  localparam int TD = SOURCES * CHANNELS;
  localparam int AW = (TD > 1) ? $clog2(TD) : 1;
  localparam int CW = (CHANNELS > 1) ? $clog2(CHANNELS) : 1;
  localparam int AccW = smam_pkg::ACC_W;

  typedef enum logic [2:0] {
    S_IDLE, S_RD, S_MUL, S_ACC, S_SLO, S_SHI, S_SUM
  } state_t;

  state_t                   state_r;
  logic          [15:0]     master_r;
  logic           [2:0]     src_r;
  logic signed   [15:0]     sample_r;
  logic                     last_r;
  logic          [CW-1:0]   ch_r;
  logic signed [AccW-1:0]   acc_r [CHANNELS];
  logic                     vld_r [TD];
  logic                     vld_rd_r;
  logic          [15:0]     rd_r;
  logic signed   [35:0]     prod_r;
  logic signed   [35:0]     lo_r;
  logic                     out_valid_r;
  logic signed   [15:0]     out_sample_r;
  logic           [2:0]     out_channel_r;
  logic                     out_last_r;
  logic                     out_clip_r;

  logic [15:0]     tbl_mem [TD];

  logic                     in_acc;
  logic                     src_ok;
  logic                     wr_en;
  logic          [AW-1:0]   wr_addr;
  logic          [15:0]     wr_level;
  logic          [AW-1:0]   rd_addr;
  logic          [15:0]     mv_eff;
  logic          [15:0]     level_eff;
  logic signed   [18:0]     mul_a;
  logic signed   [16:0]     mul_b;
  logic signed   [35:0]     mul_p;
  logic signed   [AccW-1:0] acc_cur;
  logic signed   [AccW+1:0] acc_sum;
  logic signed   [AccW-1:0] acc_sat;
  logic signed   [53:0]     scaled;
  logic signed   [23:0]     q_wide;
  logic signed   [15:0]     q_sat;
  logic                     q_clip;
  logic                     ch_last;
  logic                     out_free;

  assign in_stall = (state_r != S_IDLE);
  assign in_acc   = in_valid && !in_stall;
  assign src_ok   = {1'b0, in_source_index} < 4'(SOURCES);

  assign wr_en    = in_acc && (in_command == smam_pkg::CMD_WRITE) && src_ok &&
                    ({1'b0, in_channel_index} < 4'(CHANNELS));
  assign wr_addr  = AW'(int'(in_source_index) * CHANNELS + int'(in_channel_index));
  assign wr_level = (in_level > smam_pkg::UNITY_Q15) ? smam_pkg::UNITY_Q15 : in_level;
  assign rd_addr  = AW'(int'(src_r) * CHANNELS + int'(ch_r));

  assign mv_eff    = (master_r > smam_pkg::UNITY_Q15) ? smam_pkg::UNITY_Q15 : master_r;
  assign level_eff = vld_rd_r ? rd_r : smam_pkg::CENTRE_LEVEL;
  assign acc_cur   = acc_r[ch_r];
  assign ch_last   = (ch_r == CW'(CHANNELS - 1));
  assign out_free  = !out_valid_r || !out_stall;

  // shared multiplier: sample * level, then the two halves of acc * master
  always_comb begin
    unique case (state_r)
      S_MUL: begin
        mul_a = 19'(sample_r);
        mul_b = {1'b0, level_eff};
      end
      S_SLO: begin
        mul_a = {1'b0, acc_cur[17:0]};
        mul_b = {1'b0, mv_eff};
      end
      default: begin
        mul_a = 19'($signed(acc_cur[AccW-1:18]));
        mul_b = {1'b0, mv_eff};
      end
    endcase
  end

  assign mul_p = mul_a * mul_b;

  // accumulate with saturation at the 35-bit limits
  always_comb begin
    acc_sum = 37'(acc_cur) + 37'(prod_r);
    if (acc_sum[AccW+1:AccW-1] == 3'b000 || acc_sum[AccW+1:AccW-1] == 3'b111) begin
      acc_sat = acc_sum[AccW-1:0];
    end else if (acc_sum[AccW+1]) begin
      acc_sat = {1'b1, {(AccW-1){1'b0}}};
    end else begin
      acc_sat = {1'b0, {(AccW-1){1'b1}}};
    end
  end

  // hi part weighs 2^18; arithmetic shift by 30 rounds toward minus infinity
  always_comb begin
    scaled = {prod_r, 18'b0} + 54'(lo_r);
    q_wide = scaled[53:30];
    if (q_wide > 24'sd32767) begin
      q_sat  = 16'sh7fff;
      q_clip = 1'b1;
    end else if (q_wide < -24'sd32768) begin
      q_sat  = 16'sh8000;
      q_clip = 1'b1;
    end else begin
      q_sat  = q_wide[15:0];
      q_clip = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (wr_en) begin
      tbl_mem[wr_addr] <= wr_level;
    end
    rd_r <= tbl_mem[rd_addr];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      master_r    <= smam_pkg::UNITY_Q15;
      ch_r        <= '0;
      out_valid_r <= 1'b0;
      vld_rd_r    <= 1'b0;
      for (int i = 0; i < TD; i++) begin
        vld_r[i] <= 1'b0;
      end
      for (int i = 0; i < CHANNELS; i++) begin
        acc_r[i] <= '0;
      end
    end else begin
      if (cfg_wr_en) begin
        master_r <= cfg_wr_data;
      end
      if (wr_en) begin
        vld_r[wr_addr] <= 1'b1;
      end
      vld_rd_r <= vld_r[rd_addr];
      if (state_r == S_SUM && out_free) begin
        out_valid_r <= 1'b1;
      end else if (!out_stall) begin
        out_valid_r <= 1'b0;
      end
      unique case (state_r)
        S_IDLE: begin
          if (in_acc && in_command == smam_pkg::CMD_SAMPLE) begin
            src_r    <= in_source_index;
            sample_r <= in_sample;
            last_r   <= in_last_source;
            ch_r     <= '0;
            if (src_ok) begin
              state_r <= S_RD;
            end else if (in_last_source) begin
              state_r <= S_SLO;
            end
          end
        end
        S_RD: begin
          state_r <= S_MUL;
        end
        S_MUL: begin
          prod_r  <= mul_p;
          state_r <= S_ACC;
        end
        S_ACC: begin
          acc_r[ch_r] <= acc_sat;
          if (!ch_last) begin
            ch_r    <= ch_r + 1'b1;
            state_r <= S_RD;
          end else if (last_r) begin
            ch_r    <= '0;
            state_r <= S_SLO;
          end else begin
            state_r <= S_IDLE;
          end
        end
        S_SLO: begin
          prod_r  <= mul_p;
          state_r <= S_SHI;
        end
        S_SHI: begin
          lo_r    <= prod_r;
          prod_r  <= mul_p;
          state_r <= S_SUM;
        end
        S_SUM: begin
          if (out_free) begin
            out_sample_r  <= q_sat;
            out_clip_r    <= q_clip;
            out_channel_r <= 3'(ch_r);
            out_last_r    <= ch_last;
            acc_r[ch_r]   <= '0;
            if (ch_last) begin
              state_r <= S_IDLE;
            end else begin
              ch_r    <= ch_r + 1'b1;
              state_r <= S_SLO;
            end
          end
        end
        default: begin
          state_r <= S_IDLE;
        end
      endcase
    end
  end

  assign out_valid        = out_valid_r;
  assign out_sample       = out_sample_r;
  assign out_channel      = out_channel_r;
  assign out_last_channel = out_last_r;
  assign out_clipped      = out_clip_r;

endmodule

### rtl/smam_checker.sv
module smam_checker #(
  parameter int CHANNELS = smam_pkg::CHANNELS_DEF
) (
  input logic              clk,
  input logic              rst_n,
  input logic              out_valid,
  input logic              out_stall,
  input logic signed [15:0] out_sample,
  input logic        [2:0] out_channel,
  input logic              out_last_channel,
  input logic              out_clipped
);

  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid && $stable(out_sample) && $stable(out_channel))
    else $error("stalled result changed");

  a_chan_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> 32'(out_channel) < CHANNELS)
    else $error("result channel out of range");

  a_last_flag: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (out_last_channel == (32'(out_channel) == CHANNELS - 1)))
    else $error("last_channel disagrees with channel number");

  a_clip_value: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_clipped |-> out_sample == 16'sh7fff || out_sample == 16'sh8000)
    else $error("clipped result not at full scale");

endmodule

bind send_matrix_audio_mixer smam_checker #(.CHANNELS(CHANNELS)) u_smam_checker (.*);
